// ----- design/aes_pkg.sv -----
// ---------------------------------------------------------------------------
// AES package
// Shared types, S-box tables and GF(2^8) helpers for the AES block cipher.
// ---------------------------------------------------------------------------
`default_nettype none

package aes_pkg;

  localparam int SCHEDULE_DEPTH_DEFAULT = 60;

  localparam logic [7:0] RCON_FIRST = 8'h01;
  localparam logic [7:0] XT_POLY    = 8'h1B;

  // configuration register indexes
  localparam logic [2:0] REG_KEY_SIZE = 3'd0;
  localparam logic [2:0] REG_KEY_W0   = 3'd1;
  localparam logic [2:0] REG_KEY_W3   = 3'd4;

  localparam logic ACT_ENCRYPT = 1'b0;
  localparam logic ACT_DECRYPT = 1'b1;

  typedef struct packed {
    logic        action;
    logic [63:0] data_hi;
    logic [63:0] data_lo;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_hi;
    logic [63:0] result_lo;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [63:0] data;
  } cfg_item_t;

  // round control from sequencer to round unit
  typedef struct packed {
    logic load;     // load input block with first key xor
    logic step;     // run one round
    logic last;     // final round: no mix
    logic dec;      // inverse cipher
  } round_ctl_t;

  function automatic logic [7:0] xt(input logic [7:0] v);
    xt = {v[6:0], 1'b0} ^ (v[7] ? XT_POLY : 8'h00);
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    sbox = t[a];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    inv_sbox = t[a];
  endfunction

  function automatic logic [31:0] sbox_word(input logic [31:0] w);
    sbox_word = {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

endpackage

`default_nettype wire

// ----- design/aes_block_cipher.sv -----
// ---------------------------------------------------------------------------
// AES block cipher top level
// Key registers, sequencer and output register around the shared round unit.
// ---------------------------------------------------------------------------
// Each item runs Nr rounds (Nr = 10/12/14) on the single round unit, one round
// per cycle, after the schedule is ready. No new item is accepted until the
// result is registered; after a key write the first item also waits for the
// one-word-per-cycle key expansion.
// Reset: synchronous; registers clear to a zero 128-bit key, schedule stale.
`default_nettype none

module aes_block_cipher #(
  parameter int SCHEDULE_DEPTH = aes_pkg::SCHEDULE_DEPTH_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire aes_pkg::in_item_t   in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output aes_pkg::out_item_t       out_item,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire aes_pkg::cfg_item_t  cfg_item
);

  typedef enum logic [2:0] {S_IDLE, S_EXPSTART, S_EXPAND, S_PREP, S_LOAD, S_ROUND, S_DONE}
    state_t;

  state_t       state;
  logic [1:0]   key_len;
  logic [63:0]  key_words [4];
  logic         sched_ok;
  logic         dec;
  logic [127:0] blk;
  logic [3:0]   rnd;       // round in the round unit
  logic [3:0]   ahead;     // round whose key is addressed this cycle
  logic [3:0]   nr;
  logic [3:0]   nk;
  logic [1:0]   sel;
  logic         exp_start, exp_busy;
  logic [3:0]   rd_round;
  logic [127:0] rd_key;
  logic [127:0] st;
  aes_pkg::round_ctl_t ctl;

  // key size clamp, three as 256, limited by store depth
  always_comb begin
    sel = (key_len == 2'd3) ? 2'd2 : key_len;
    if (sel == 2'd2 && SCHEDULE_DEPTH < 60) sel = 2'd1;
    if (sel == 2'd1 && SCHEDULE_DEPTH < 52) sel = 2'd0;
    nk = 4'd4 + {1'b0, sel, 1'b0};
    nr = nk + 4'd6;
  end

  // config only between items; it wins over a new item
  assign cfg_ready = (state == S_IDLE);
  assign in_ready  = (state == S_IDLE) && !cfg_valid;
  assign exp_start = (state == S_EXPSTART);

  // round key addressed in the cycle before the round unit uses it
  always_comb begin
    unique case (state)
      S_PREP:  ahead = 4'd0;
      S_LOAD:  ahead = 4'd1;
      S_ROUND: ahead = (rnd == nr) ? rnd : rnd + 4'd1;
      default: ahead = 4'd0;
    endcase
    rd_round = dec ? nr - ahead : ahead;
  end

  always_comb begin
    ctl.load = (state == S_LOAD);
    ctl.step = (state == S_ROUND);
    ctl.last = (rnd == nr);
    ctl.dec  = dec;
  end

  aes_key_expand #(.SCHEDULE_DEPTH(SCHEDULE_DEPTH)) u_key (
    .clk(clk), .rst(rst), .start(exp_start), .nk(nk),
    .key({key_words[0], key_words[1], key_words[2], key_words[3]}),
    .rd_round(rd_round), .rd_key(rd_key), .busy(exp_busy)
  );

  aes_round u_round (
    .clk(clk), .ctl(ctl), .block_in(blk), .round_key(rd_key), .state(st)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_len <= 2'd0;
      for (int i = 0; i < 4; i++) key_words[i] <= 64'h0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_item.index == aes_pkg::REG_KEY_SIZE) begin
        key_len <= cfg_item.data[1:0];
      end else if (cfg_item.index >= aes_pkg::REG_KEY_W0 &&
                   cfg_item.index <= aes_pkg::REG_KEY_W3) begin
        key_words[2'(cfg_item.index - aes_pkg::REG_KEY_W0)] <= cfg_item.data;
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sched_ok  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            dec <= in_item.action;
            blk <= {in_item.data_hi, in_item.data_lo};
            rnd <= 4'd0;
            state <= sched_ok ? S_PREP : S_EXPSTART;
          end
        end
        S_EXPSTART: state <= S_EXPAND;
        S_EXPAND: begin
          if (!exp_busy) begin
            sched_ok <= 1'b1;
            state <= S_PREP;
          end
        end
        S_PREP: state <= S_LOAD;
        S_LOAD: begin
          // key for the first key add is now on rd_key
          rnd   <= 4'd1;
          state <= S_ROUND;
        end
        S_ROUND: begin
          if (rnd == nr) state <= S_DONE;
          else rnd <= rnd + 4'd1;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_item  <= {st[127:64], st[63:0]};
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cfg_valid && cfg_ready && cfg_item.index <= aes_pkg::REG_KEY_W3) sched_ok <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- design/aes_round.sv -----
// ---------------------------------------------------------------------------
// AES round unit
// Shared round datapath: one forward or inverse round per cycle while step is set, on a
// 128-bit state register, keyed by the round key supplied this cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module aes_round (
  input  wire logic                 clk,
  input  wire aes_pkg::round_ctl_t  ctl,
  input  wire logic [127:0]         block_in,
  input  wire logic [127:0]         round_key,
  output logic      [127:0]         state
);

  logic [7:0] s  [16];
  logic [7:0] sh [16];
  logic [7:0] sb [16];
  logic [7:0] mx [16];
  logic [7:0] ak [16];
  logic [127:0] fwd_out;
  logic [127:0] inv_out;

  // byte view, byte 0 in the top bits
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = state[127-8*i -: 8];
    end
  end

  // forward: sub, shift; inverse: shift, sub
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (ctl.dec) begin
          sh[r+4*((c+r)&3)] = s[r+4*c];
        end else begin
          sh[r+4*c] = aes_pkg::sbox(s[r+4*((c+r)&3)]);
        end
      end
    end
    for (int i = 0; i < 16; i++) begin
      sb[i] = ctl.dec ? aes_pkg::inv_sbox(sh[i]) : sh[i];
    end
  end

  // forward mix columns on sb, key add afterwards; also the key add for the inverse path
  always_comb begin
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = sb[4*c]; a1 = sb[4*c+1]; a2 = sb[4*c+2]; a3 = sb[4*c+3];
      mx[4*c]   = aes_pkg::xt(a0) ^ aes_pkg::xt(a1) ^ a1 ^ a2 ^ a3;
      mx[4*c+1] = a0 ^ aes_pkg::xt(a1) ^ aes_pkg::xt(a2) ^ a2 ^ a3;
      mx[4*c+2] = a0 ^ a1 ^ aes_pkg::xt(a2) ^ aes_pkg::xt(a3) ^ a3;
      mx[4*c+3] = aes_pkg::xt(a0) ^ a0 ^ a1 ^ a2 ^ aes_pkg::xt(a3);
    end
    for (int i = 0; i < 16; i++) begin
      ak[i] = sb[i] ^ round_key[127-8*i -: 8];
      fwd_out[127-8*i -: 8] = (ctl.last ? sb[i] : mx[i]) ^ round_key[127-8*i -: 8];
    end
  end

  // inverse: key add then inverse mix columns
  always_comb begin
    logic [7:0] b0, b1, b2, b3;
    logic [7:0] x1 [4];
    logic [7:0] x2 [4];
    logic [7:0] x3 [4];
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        x1[k] = aes_pkg::xt(ak[4*c+k]);
        x2[k] = aes_pkg::xt(x1[k]);
        x3[k] = aes_pkg::xt(x2[k]);
      end
      b0 = ak[4*c]; b1 = ak[4*c+1]; b2 = ak[4*c+2]; b3 = ak[4*c+3];
      // 14 = x3^x2^x1, 11 = x3^x1^1, 13 = x3^x2^1, 9 = x3^1
      inv_out[127-32*c -: 8] = (x3[0]^x2[0]^x1[0]) ^ (x3[1]^x1[1]^b1)
                             ^ (x3[2]^x2[2]^b2) ^ (x3[3]^b3);
      inv_out[119-32*c -: 8] = (x3[0]^b0) ^ (x3[1]^x2[1]^x1[1])
                             ^ (x3[2]^x1[2]^b2) ^ (x3[3]^x2[3]^b3);
      inv_out[111-32*c -: 8] = (x3[0]^x2[0]^b0) ^ (x3[1]^b1)
                             ^ (x3[2]^x2[2]^x1[2]) ^ (x3[3]^x1[3]^b3);
      inv_out[103-32*c -: 8] = (x3[0]^x1[0]^b0) ^ (x3[1]^x2[1]^b1)
                             ^ (x3[2]^b2) ^ (x3[3]^x2[3]^x1[3]);
      if (ctl.last) begin
        for (int k = 0; k < 4; k++) begin
          inv_out[127-32*c-8*k -: 8] = ak[4*c+k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      state <= block_in ^ round_key;
    end else if (ctl.step) begin
      state <= ctl.dec ? inv_out : fwd_out;
    end
  end

endmodule

`default_nettype wire

// ----- design/aes_key_expand.sv -----
// ---------------------------------------------------------------------------
// AES key schedule store
// Expands the key one word per cycle into a word memory and serves four
// consecutive round-key words per read, read data registered.
// ---------------------------------------------------------------------------
`default_nettype none

module aes_key_expand #(
  parameter int SCHEDULE_DEPTH = aes_pkg::SCHEDULE_DEPTH_DEFAULT
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,      // begin expansion
  input  wire logic [3:0]   nk,         // 4, 6 or 8
  input  wire logic [255:0] key,
  input  wire logic [3:0]   rd_round,
  output logic      [127:0] rd_key,
  output logic              busy
);

  // round keys stored as rows of four words; written one word at a time
  localparam int ROWS = (SCHEDULE_DEPTH + 3) / 4;

  logic [31:0]  mem [ROWS][4];
  logic [5:0]   idx;
  logic [5:0]   total;
  logic [31:0]  win [8];    // last nk words, oldest first
  logic [2:0]   phase;      // idx mod nk
  logic [7:0]   rc;
  logic [31:0]  t;
  logic [31:0]  w_new;
  logic [31:0]  w_wr;

  // next schedule word; the first nk words are the key itself
  always_comb begin
    t = win[3'(nk - 4'd1)];
    if (phase == 3'd0) begin
      t = aes_pkg::sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
    end else if (nk == 4'd8 && phase == 3'd4) begin
      t = aes_pkg::sbox_word(t);
    end
    w_new = win[0] ^ t;
    w_wr  = (idx < {2'b00, nk}) ? key[255 - 32*idx[2:0] -: 32] : w_new;
  end

  // expansion counters and word window
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy  <= 1'b1;
      idx   <= 6'd0;
      total <= {nk + 4'd7, 2'b00};
      phase <= 3'd0;
      rc    <= aes_pkg::RCON_FIRST;
    end else if (busy) begin
      for (int i = 0; i < 7; i++) begin
        win[i] <= (4'(i) == nk - 4'd1) ? w_wr : win[i+1];
      end
      win[7] <= w_wr;
      idx    <= idx + 6'd1;
      phase  <= (phase == 3'(nk - 4'd1)) ? 3'd0 : phase + 3'd1;
      if (idx >= {2'b00, nk} && phase == 3'd0) begin
        rc <= aes_pkg::xt(rc);
      end
      if (idx == total - 6'd1) begin
        busy <= 1'b0;
      end
    end
  end

  // one word written per cycle while busy
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[idx[5:2]][idx[1:0]] <= w_wr;
    end
  end

  always_ff @(posedge clk) begin
    rd_key <= {mem[rd_round][0], mem[rd_round][1], mem[rd_round][2], mem[rd_round][3]};
  end

endmodule

`default_nettype wire

// ----- design/aes_block_cipher_checker.sv -----
// ---------------------------------------------------------------------------
// AES block cipher port checker
// Port-level properties of the block, attached by bind.
// ---------------------------------------------------------------------------
`default_nettype none

module aes_block_cipher_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire aes_pkg::out_item_t out_item
);

  // block takes no new item the cycle after accepting one
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("ready after accept");

  // a result cannot appear right after acceptance
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> ##1 !$rose(out_valid)) else $error("early result");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item)) else $error("result dropped");

  // after reset no result is pending
  a_rst: assert property (@(posedge clk) $past(rst) |-> !out_valid) else $error("result at reset");

endmodule

bind aes_block_cipher aes_block_cipher_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
);

`default_nettype wire
